// ===== rtl/apulc_pkg.sv =====
// Package for the triangle/noise length, linear counter and envelope unit.
// Holds register offsets, the transaction opcode type and the length load table.
// No dependencies.
package apulc_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    localparam logic [3:0] REG_TRI_LINEAR   = 4'd0;
    localparam logic [3:0] REG_TRI_LENGTH   = 4'd3;
    localparam logic [3:0] REG_NOISE_ENV    = 4'd4;
    localparam logic [3:0] REG_NOISE_LENGTH = 4'd7;
    localparam logic [3:0] REG_STATUS       = 4'd13;

    localparam logic [3:0] ENV_FULL = 4'd15;

    localparam logic [7:0] LEN_TAB [32] = '{
        8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
        8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
        8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
        8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
    };

endpackage

// ===== rtl/apu_length_envelope_linear_counters_unit.sv =====
// Top level: triangle linear counter, noise envelope and both length counters.
// Each input transaction goes through the input register, then the result register.
// Throughput: one transaction per cycle; a stalled result holds the input register.
// Reset (i_rst_n low, synchronous) empties both stages and returns the counter
// state to its power-up values. Depends on apulc_pkg.
module apu_length_envelope_linear_counters_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] reg_offset, [11:4] write_data, [12] half_frame, [15:13] zero
    input  logic [apulc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] opcode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] tri_gate, [4:1] noise_level, [5] noise_gate, [13:6] tri_length_left,
    // [21:14] noise_length_left, [28:22] linear_count, [31:29] zero
    output logic [apulc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import apulc_pkg::*;

    logic       r_in_valid;
    t_opcode    r_in_opcode;
    logic [3:0] r_in_offset;
    logic [7:0] r_in_data;
    logic       r_in_half;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic       r_tri_en,       n_tri_en;
    logic       r_noise_en,     n_noise_en;
    logic [7:0] r_tri_len,      n_tri_len;
    logic [7:0] r_noise_len,    n_noise_len;
    logic [6:0] r_lin_val,      n_lin_val;
    logic [6:0] r_lin_reload,   n_lin_reload;
    logic       r_lin_ctrl,     n_lin_ctrl;
    logic       r_lin_pend,     n_lin_pend;
    logic [3:0] r_env_val,      n_env_val;
    logic [3:0] r_env_div,      n_env_div;
    logic [3:0] r_env_per,      n_env_per;
    logic       r_env_const,    n_env_const;
    logic       r_env_loop,     n_env_loop;
    logic       r_env_pend,     n_env_pend;

    logic       in_move;
    logic       s_accept;
    logic [4:0] div_inc;
    logic       env_clk;
    logic [M_TDATA_W-1:0] n_out_data;

    assign in_move       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || in_move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_tri_en     = r_tri_en;
        n_noise_en   = r_noise_en;
        n_tri_len    = r_tri_len;
        n_noise_len  = r_noise_len;
        n_lin_val    = r_lin_val;
        n_lin_reload = r_lin_reload;
        n_lin_ctrl   = r_lin_ctrl;
        n_lin_pend   = r_lin_pend;
        n_env_val    = r_env_val;
        n_env_div    = r_env_div;
        n_env_per    = r_env_per;
        n_env_const  = r_env_const;
        n_env_loop   = r_env_loop;
        n_env_pend   = r_env_pend;
        div_inc      = {1'b0, r_env_div} + 5'd1;
        env_clk      = 1'b0;

        if (r_in_opcode == OP_WRITE) begin
            case (r_in_offset)
                REG_TRI_LINEAR: begin
                    n_lin_ctrl   = r_in_data[7];
                    n_lin_reload = r_in_data[6:0];
                end
                REG_TRI_LENGTH: begin
                    n_lin_pend = 1'b1;
                    if (r_tri_en) begin
                        n_tri_len = LEN_TAB[r_in_data[7:3]];
                    end
                end
                REG_NOISE_ENV: begin
                    n_env_per   = r_in_data[3:0];
                    n_env_const = r_in_data[4];
                    n_env_loop  = r_in_data[5];
                end
                REG_NOISE_LENGTH: begin
                    n_env_pend = 1'b1;
                    if (r_noise_en) begin
                        n_noise_len = LEN_TAB[r_in_data[7:3]];
                    end
                end
                REG_STATUS: begin
                    n_tri_en   = r_in_data[2];
                    n_noise_en = r_in_data[3];
                    if (!r_in_data[2]) begin
                        n_tri_len = 8'd0;
                    end
                    if (!r_in_data[3]) begin
                        n_noise_len = 8'd0;
                    end
                end
                default: ;
            endcase
        end else begin
            if (r_lin_pend) begin
                n_lin_val = r_lin_reload;
            end else if (r_lin_val != 7'd0) begin
                n_lin_val = r_lin_val - 7'd1;
            end
            if (!r_lin_ctrl) begin
                n_lin_pend = 1'b0;
            end

            if (r_env_pend) begin
                n_env_pend = 1'b0;
                n_env_val  = ENV_FULL;
                n_env_div  = 4'd0;
            end else if (div_inc > {1'b0, r_env_per}) begin
                env_clk   = 1'b1;
                n_env_div = 4'd0;
            end else begin
                n_env_div = div_inc[3:0];
            end
            if (env_clk) begin
                if (r_env_loop && r_env_val == 4'd0) begin
                    n_env_val = ENV_FULL;
                end else if (r_env_val != 4'd0) begin
                    n_env_val = r_env_val - 4'd1;
                end
            end

            if (r_in_half) begin
                if (!r_lin_ctrl && r_tri_len != 8'd0) begin
                    n_tri_len = r_tri_len - 8'd1;
                end
                if (!r_env_loop && r_noise_len != 8'd0) begin
                    n_noise_len = r_noise_len - 8'd1;
                end
            end
        end

        n_out_data = {
            3'd0,
            n_lin_val,
            n_noise_len,
            n_tri_len,
            n_noise_en && n_noise_len != 8'd0,
            n_env_const ? n_env_per : n_env_val,
            n_tri_en && n_lin_val != 7'd0 && n_tri_len != 8'd0
        };
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_opcode <= t_opcode'(s_axis_tuser);
            r_in_offset <= s_axis_tdata[3:0];
            r_in_data   <= s_axis_tdata[11:4];
            r_in_half   <= s_axis_tdata[12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri_en     <= 1'b1;
            r_noise_en   <= 1'b1;
            r_tri_len    <= 8'd0;
            r_noise_len  <= 8'd0;
            r_lin_val    <= 7'd0;
            r_lin_reload <= 7'd0;
            r_lin_ctrl   <= 1'b0;
            r_lin_pend   <= 1'b1;
            r_env_val    <= 4'd0;
            r_env_div    <= 4'd0;
            r_env_per    <= 4'd0;
            r_env_const  <= 1'b0;
            r_env_loop   <= 1'b0;
            r_env_pend   <= 1'b1;
        end else if (in_move) begin
            r_tri_en     <= n_tri_en;
            r_noise_en   <= n_noise_en;
            r_tri_len    <= n_tri_len;
            r_noise_len  <= n_noise_len;
            r_lin_val    <= n_lin_val;
            r_lin_reload <= n_lin_reload;
            r_lin_ctrl   <= n_lin_ctrl;
            r_lin_pend   <= n_lin_pend;
            r_env_val    <= n_env_val;
            r_env_div    <= n_env_div;
            r_env_per    <= n_env_per;
            r_env_const  <= n_env_const;
            r_env_loop   <= n_env_loop;
            r_env_pend   <= n_env_pend;
        end
    end

`ifndef SYNTHESIS
    a_tri_off_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tri_en |-> r_tri_len == 8'd0)
        else $error("triangle length nonzero while disabled");

    a_noise_off_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_noise_en |-> r_noise_len == 8'd0)
        else $error("noise length nonzero while disabled");

    a_move_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move |=> r_out_valid)
        else $error("result lost after stage transfer");
`endif

endmodule
